### src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types, constants and helpers of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int POOL_COUNT  = 4;
   localparam int BLOCK_LIMIT = 64;
   localparam int POOL_W      = 2;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int STRIDE_W    = 13;
   localparam int OFFSET_W    = 18;
   localparam int FAIL_W      = 16;
   localparam int PROD_W      = IDX_W + STRIDE_W;
   localparam int LINK_DEPTH  = POOL_COUNT * BLOCK_LIMIT;
   localparam int LINK_ADDR_W = $clog2(LINK_DEPTH);
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = STRIDE_W;

   localparam logic [CNT_W-1:0]    COUNT_RESET  = CNT_W'(64);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(64);
   localparam logic [CNT_W-1:0]    USE_MAX      = '1;
   localparam logic [FAIL_W-1:0]   FAIL_MAX     = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_BASE = CSR_IDX_W'(POOL_COUNT);
   localparam logic [CSR_IDX_W-1:0] CSR_END         = CSR_IDX_W'(2 * POOL_COUNT);

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_REINIT = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      mode_type          mode;
      logic [POOL_W-1:0] pool;
      logic [IDX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    granted_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [CNT_W-1:0]    used_count;
      logic [CNT_W-1:0]    peak_used;
      logic [FAIL_W-1:0]   fail_count;
   } rsp_type;

   typedef struct packed {
      logic                   en;
      logic [LINK_ADDR_W-1:0] addr;
      logic [IDX_W-1:0]       data;
   } link_wr_type;

   typedef logic [POOL_COUNT-1:0][CNT_W-1:0]    count_vec_type;
   typedef logic [POOL_COUNT-1:0][STRIDE_W-1:0] stride_vec_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(BLOCK_LIMIT);
      return (c > lim) ? lim : c;
   endfunction

endpackage

### src/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// several pools of fixed-size blocks, each with a lifo free list
//
//   port group   direction   flow control   carries
//   req_*        in          valid/stall    mode, pool, block index
//   rsp_*        out         valid/stall    status, grant, offset, counters
//   csr_*        in          valid/ready    register index, write data
//
// one request per cycle sustained while rsp_stall is low; a request accepted
// at one edge has its response registered at the next edge it can advance
// the link store is read as the request is accepted, addressed by the head
// the request will see, with a bypass for a link written at the same edge
// synchronous active-high reset empties every list and clears the counters
// a stalled response holds the request register, which then stalls req_*
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fbpa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fbpa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fbpa_pkg::*;

   logic                   req_valid_ff, req_valid_in;
   req_type                req_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   logic                   advance, fire, accept;
   count_vec_type          count;
   stride_vec_type         stride;
   link_wr_type            link_wr;
   logic [LINK_ADDR_W-1:0] link_rd_addr;
   logic [IDX_W-1:0]       link_rd_data;
   rsp_type                rsp_next;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   fbpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .count_ff  (count),
      .stride_ff (stride)
   );

   fbpa_link_ram u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (link_wr),
      .rd_en   (accept),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   fbpa_pool_ctrl u_pool_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .req          (req_ff),
      .next_pool    (req_data.pool),
      .count        (count),
      .stride       (stride),
      .link_rd_data (link_rd_data),
      .link_wr      (link_wr),
      .link_rd_addr (link_rd_addr),
      .rsp          (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/fbpa_csr.sv
// ----------------------------------------------------------------------------
// fbpa_csr
// per-pool block count and stride registers
// ----------------------------------------------------------------------------
module fbpa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output fbpa_pkg::count_vec_type           count_ff,
   output fbpa_pkg::stride_vec_type          stride_ff
);
   import fbpa_pkg::*;

   count_vec_type  count_in;
   stride_vec_type stride_in;
   logic [POOL_W-1:0] sel;

   assign csr_ready = 1'b1;
   assign sel       = csr_index[POOL_W-1:0];

   always_comb begin
      count_in  = count_ff;
      stride_in = stride_ff;
      if (csr_valid) begin
         if (csr_index < CSR_STRIDE_BASE) begin
            count_in[sel] = csr_wdata[CNT_W-1:0];
         end else if (csr_index < CSR_END) begin
            stride_in[sel] = csr_wdata[STRIDE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_COUNT; i++) begin
            count_ff[i]  <= COUNT_RESET;
            stride_ff[i] <= STRIDE_RESET;
         end
      end else begin
         count_ff  <= count_in;
         stride_ff <= stride_in;
      end
   end

endmodule

### src/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// fbpa_link_ram
// successor store of the recycled lists, registered read with write bypass
// ----------------------------------------------------------------------------
module fbpa_link_ram (
   input  logic                               clock,
   input  logic                               reset,
   input  fbpa_pkg::link_wr_type              wr,
   input  logic                               rd_en,
   input  logic [fbpa_pkg::LINK_ADDR_W-1:0]   rd_addr,
   output logic [fbpa_pkg::IDX_W-1:0]         rd_data
);
   import fbpa_pkg::*;

   logic [IDX_W-1:0] link_mem_ff [LINK_DEPTH];
   logic [IDX_W-1:0] rd_ff;
   logic [IDX_W-1:0] byp_ff;
   logic             byp_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_ff  <= link_mem_ff[rd_addr];
         byp_ff <= wr.data;
      end
   end

   // same-edge write to the address being read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd_en) begin
         byp_hit_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   assign rd_data = byp_hit_ff ? byp_ff : rd_ff;

endmodule

### src/fbpa_pool_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_pool_ctrl
// per-pool list heads, fresh counts, stats, one request per cycle on fire
// ----------------------------------------------------------------------------
module fbpa_pool_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  fbpa_pkg::req_type                  req,
   input  logic [fbpa_pkg::POOL_W-1:0]        next_pool,
   input  fbpa_pkg::count_vec_type            count,
   input  fbpa_pkg::stride_vec_type           stride,
   input  logic [fbpa_pkg::IDX_W-1:0]         link_rd_data,
   output fbpa_pkg::link_wr_type              link_wr,
   output logic [fbpa_pkg::LINK_ADDR_W-1:0]   link_rd_addr,
   output fbpa_pkg::rsp_type                  rsp
);
   import fbpa_pkg::*;

   logic [POOL_COUNT-1:0]                head_valid_ff, head_valid_in;
   logic [POOL_COUNT-1:0][IDX_W-1:0]     head_ff, head_in;
   logic [POOL_COUNT-1:0][CNT_W-1:0]     fresh_ff, fresh_in;
   logic [POOL_COUNT-1:0][CNT_W-1:0]     use_ff, use_in;
   logic [POOL_COUNT-1:0][CNT_W-1:0]     peak_ff, peak_in;
   logic [POOL_COUNT-1:0][FAIL_W-1:0]    fail_ff, fail_in;

   logic                 c_valid;
   logic [IDX_W-1:0]     c_head;
   logic [CNT_W-1:0]     c_fresh, c_use, c_peak, c_limit;
   logic [FAIL_W-1:0]    c_fail;
   logic                 got;
   logic [IDX_W-1:0]     granted;
   status_type           status;
   logic [PROD_W-1:0]    product;
   logic [POOL_W-1:0]    p;

   assign p = req.pool;

   always_comb begin
      c_valid = head_valid_ff[p];
      c_head  = head_ff[p];
      c_fresh = fresh_ff[p];
      c_use   = use_ff[p];
      c_peak  = peak_ff[p];
      c_fail  = fail_ff[p];
      c_limit = clamp_count(count[p]);
      got     = 1'b0;
      granted = '0;
      status  = ST_OK;
      link_wr.en   = 1'b0;
      link_wr.addr = {p, req.block_index};
      link_wr.data = head_ff[p];
      unique case (req.mode)
         MODE_ALLOC: begin
            if (head_valid_ff[p]) begin
               got     = 1'b1;
               granted = head_ff[p];
               // a self link marks the tail of the list
               if (link_rd_data == head_ff[p]) begin
                  c_valid = 1'b0;
               end else begin
                  c_head = link_rd_data;
               end
            end else if (fresh_ff[p] != '0) begin
               got     = 1'b1;
               c_fresh = fresh_ff[p] - CNT_W'(1);
               granted = c_fresh[IDX_W-1:0];
            end
            if (got) begin
               if (c_use != USE_MAX) begin
                  c_use = c_use + CNT_W'(1);
               end
               if (c_use > c_peak) begin
                  c_peak = c_use;
               end
            end else begin
               status = ST_EMPTY;
               if (c_fail != FAIL_MAX) begin
                  c_fail = c_fail + FAIL_W'(1);
               end
            end
         end
         MODE_FREE: begin
            if ({1'b0, req.block_index} >= c_limit) begin
               status = ST_RANGE;
            end else begin
               link_wr.en   = fire;
               link_wr.data = head_valid_ff[p] ? head_ff[p] : req.block_index;
               c_head  = req.block_index;
               c_valid = 1'b1;
               if (c_use != '0) begin
                  c_use = c_use - CNT_W'(1);
               end
            end
         end
         MODE_REINIT: begin
            c_valid = 1'b0;
            c_head  = '0;
            c_fresh = c_limit;
            c_use   = '0;
            c_peak  = '0;
         end
         default: begin
         end
      endcase
   end

   assign product = PROD_W'(granted) * PROD_W'(stride[p]);

   always_comb begin
      rsp.status        = status;
      rsp.granted_index = granted;
      rsp.byte_offset   = product[OFFSET_W-1:0];
      rsp.used_count    = c_use;
      rsp.peak_used     = c_peak;
      rsp.fail_count    = c_fail;
   end

   always_comb begin
      for (int i = 0; i < POOL_COUNT; i++) begin
         if (fire && (p == POOL_W'(i))) begin
            head_valid_in[i] = c_valid;
            head_in[i]       = c_head;
            fresh_in[i]      = c_fresh;
            use_in[i]        = c_use;
            peak_in[i]       = c_peak;
            fail_in[i]       = c_fail;
         end else begin
            head_valid_in[i] = head_valid_ff[i];
            head_in[i]       = head_ff[i];
            fresh_in[i]      = fresh_ff[i];
            use_in[i]        = use_ff[i];
            peak_in[i]       = peak_ff[i];
            fail_in[i]       = fail_ff[i];
         end
      end
   end

   // prefetch the successor of the head the next request will see
   assign link_rd_addr = {next_pool, head_in[next_pool]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_COUNT; i++) begin
            head_valid_ff[i] <= 1'b0;
            head_ff[i]       <= '0;
            fresh_ff[i]      <= clamp_count(COUNT_RESET);
            use_ff[i]        <= '0;
            peak_ff[i]       <= '0;
            fail_ff[i]       <= '0;
         end
      end else begin
         head_valid_ff <= head_valid_in;
         head_ff       <= head_in;
         fresh_ff      <= fresh_in;
         use_ff        <= use_in;
         peak_ff       <= peak_in;
         fail_ff       <= fail_in;
      end
   end

endmodule
